// File: design/hcsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the hex digit decoder of the hex color spec parser.
// Depends on nothing; imported by hcsp_step and hex_color_spec_parser.
package hcsp_pkg;

   localparam int NIBBLE_COUNT = 12;
   localparam int POS_WIDTH    = 4;

   localparam logic [7:0]           HASH_CHAR    = 8'h23;   // '#'
   localparam logic [7:0]           ALPHA_OPAQUE = 8'hFF;
   localparam logic [POS_WIDTH-1:0] POS_SATURATE = 4'd14;
   localparam logic [POS_WIDTH-1:0] POS_LAST_NIB = 4'd12;

   // Accepted total lengths: '#' plus 3, 6, 9 or 12 digits
   localparam logic [POS_WIDTH-1:0] LEN_DIGITS_1 = 4'd4;
   localparam logic [POS_WIDTH-1:0] LEN_DIGITS_2 = 4'd7;
   localparam logic [POS_WIDTH-1:0] LEN_DIGITS_3 = 4'd10;
   localparam logic [POS_WIDTH-1:0] LEN_DIGITS_4 = 4'd13;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [31:0] pixel;
   } rsp_type;

   typedef logic [NIBBLE_COUNT-1:0][3:0] nibble_vec_type;

   // Next-state controls produced by the per-character step
   typedef struct packed {
      logic [POS_WIDTH-1:0] pos_next;
      logic                 bad_next;
      logic                 wr_en;
      logic [POS_WIDTH-1:0] wr_idx;
      logic [3:0]           wr_nib;
   } step_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type d;
      d.is_hex = 1'b1;
      d.value  = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         d.value = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         d.value = c[3:0] + 4'd9;
      end else begin
         d.is_hex = 1'b0;
      end
      return d;
   endfunction

endpackage

// File: design/hcsp_step.sv
`timescale 1ns / 1ps
// Per-character decode, state update and result assembly of the hex color spec parser.
// Depends on hcsp_pkg.
module hcsp_step
   import hcsp_pkg::*;
(
   input  logic [7:0]           char_code,
   input  logic [POS_WIDTH-1:0] pos,
   input  logic                 bad,
   input  nibble_vec_type       nibbles,
   output step_type             step,
   output rsp_type              result
);

   hex_type             dig;
   logic                in_digits;
   logic [POS_WIDTH-1:0] len;
   nibble_vec_type      merged;
   logic                ok;
   logic [15:0]         red;
   logic [15:0]         green;
   logic [15:0]         blue;

   // Decode the byte and work out the next position and error flag
   always_comb begin
      dig       = hex_digit(char_code);
      in_digits = (pos != '0) && (pos <= POS_LAST_NIB);
      len       = (pos == POS_SATURATE) ? POS_SATURATE : pos + 4'd1;

      step.pos_next = len;
      step.bad_next = bad
                      | ((pos == '0) && (char_code != HASH_CHAR))
                      | (in_digits && !dig.is_hex);
      step.wr_en    = in_digits && dig.is_hex;
      step.wr_idx   = pos - 4'd1;
      step.wr_nib   = dig.value;
   end

   // Stored digits with this byte's digit folded in
   always_comb begin
      for (int i = 0; i < NIBBLE_COUNT; i++) begin
         merged[i] = (step.wr_en && (step.wr_idx == POS_WIDTH'(i))) ? step.wr_nib : nibbles[i];
      end
   end

   // Split the digits into left-aligned components by total length
   always_comb begin
      ok    = 1'b1;
      red   = '0;
      green = '0;
      blue  = '0;
      case (len)
         LEN_DIGITS_1: begin
            red   = {merged[0], 12'h000};
            green = {merged[1], 12'h000};
            blue  = {merged[2], 12'h000};
         end
         LEN_DIGITS_2: begin
            red   = {merged[0], merged[1], 8'h00};
            green = {merged[2], merged[3], 8'h00};
            blue  = {merged[4], merged[5], 8'h00};
         end
         LEN_DIGITS_3: begin
            red   = {merged[0], merged[1], merged[2], 4'h0};
            green = {merged[3], merged[4], merged[5], 4'h0};
            blue  = {merged[6], merged[7], merged[8], 4'h0};
         end
         LEN_DIGITS_4: begin
            red   = {merged[0], merged[1], merged[2], merged[3]};
            green = {merged[4], merged[5], merged[6], merged[7]};
            blue  = {merged[8], merged[9], merged[10], merged[11]};
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      ok = ok && !step.bad_next;

      // A rejected spec reports all zeros
      if (ok) begin
         result.valid_res = 1'b1;
         result.red       = red;
         result.green     = green;
         result.blue      = blue;
         result.pixel     = {ALPHA_OPAQUE, red[15:8], green[15:8], blue[15:8]};
      end else begin
         result = '0;
      end
   end

endmodule

// File: design/hex_color_spec_parser.sv
`timescale 1ns / 1ps
// Top level of the hex color spec parser: input register, parse state and result register.
// Depends on hcsp_pkg and hcsp_step.
//
//   channel  ports                         payload   direction
//   request  req_valid req_stall req_data   req_type  in: one spec byte, last flag
//   response rsp_valid rsp_stall rsp_data   rsp_type  out: one result per spec
//
// One byte is taken every cycle while the input does not stall; the rate is set by the
// combinational step logic between the input register and the parse state / result register.
// A spec's result is loaded into the result register as its last byte leaves the input register.
// Reset empties both registers and returns the parser to the start of a spec.
// A stalled response holds the result; non-last bytes keep flowing, and a last byte
// waits in the input register until the result register frees up.
module hex_color_spec_parser
   import hcsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   req_type              in_data_ff;
   logic [POS_WIDTH-1:0] pos_ff;
   logic                 bad_ff;
   nibble_vec_type       nibble_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   rsp_type              out_data_ff;
   logic                 out_free;
   logic                 step_fire;
   step_type             step;
   rsp_type              result;

   hcsp_step u_step (
      .char_code (in_data_ff.char_code),
      .pos       (pos_ff),
      .bad       (bad_ff),
      .nibbles   (nibble_ff),
      .step      (step),
      .result    (result)
   );

   // Handshake: a last byte needs room in the result register
   assign out_free     = !out_valid_ff || !rsp_stall;
   assign step_fire    = in_valid_ff && (!in_data_ff.is_last || out_free);
   assign req_stall    = in_valid_ff && !step_fire;
   assign in_valid_in  = req_valid || (in_valid_ff && !step_fire);
   assign out_valid_in = (step_fire && in_data_ff.is_last) || (out_valid_ff && !out_free);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Parse state; a last byte returns it to the start of a spec
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         bad_ff <= 1'b0;
      end else if (step_fire) begin
         if (in_data_ff.is_last) begin
            pos_ff <= '0;
            bad_ff <= 1'b0;
         end else begin
            pos_ff <= step.pos_next;
            bad_ff <= step.bad_next;
         end
      end
      if (step_fire && step.wr_en) begin
         nibble_ff[step.wr_idx] <= step.wr_nib;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (step_fire && in_data_ff.is_last) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Checks
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_SATURATE)
      else $error("position count beyond saturation");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      step_fire && in_data_ff.is_last |=> out_valid_ff && pos_ff == '0 && !bad_ff)
      else $error("last byte did not produce a result and restart");

   a_pixel_alpha: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.valid_res |-> out_data_ff.pixel[31:24] == ALPHA_OPAQUE)
      else $error("valid result without opaque alpha");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.valid_res |-> out_data_ff == '0)
      else $error("rejected spec with nonzero fields");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_data_ff.is_last && out_valid_ff)
      else $error("input stalled without a waiting last byte");

endmodule

// File: tb/hex_color_spec_parser_test.sv
`timescale 1ns / 1ps
// Self-checking bench for hex_color_spec_parser: a directed spec table, then random specs.
// Every accepted transfer updates a behavioral parse model. Depends on hcsp_pkg and the design.
module hex_color_spec_parser_test;
   import hcsp_pkg::*;

   // One directed spec: bytes right-aligned, first byte at text[len-1]
   typedef struct {
      logic [15:0][7:0] text;
      int               len;
      bit               typed;
      rsp_type          want;
   } spec_row;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Parse model state
   logic [3:0] parse_pos;
   logic [3:0] parse_nibs [NIBBLE_COUNT];
   logic       parse_bad;

   rsp_type color_q [$];     // colors still owed by the block, oldest first
   rsp_type color_front;
   spec_row dir_specs [4];

   bit quiet       = 1'b0;   // no idling on either side
   int hold_asks   = 0;      // bumped by stimulus to request a long response hold-off
   int hold_served = 0;
   int hold_left   = 0;
   int chars_sent  = 0;
   int specs_done  = 0;
   int good_specs  = 0;
   int checked     = 0;
   int faults      = 0;

   hex_color_spec_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   initial begin
      #400_000;
      $display("hex_color_spec_parser_test: errors");
      $finish;
   end

   function automatic void parse_clear();
      parse_pos = '0;
      parse_bad = 1'b0;
      foreach (parse_nibs[i]) parse_nibs[i] = '0;
   endfunction

   // -1 for anything that is not a hex digit
   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   // Left-align a run of stored nibbles into 16 bits
   function automatic logic [15:0] gather(input int first, input int digits);
      logic [15:0] v = '0;
      for (int i = 0; i < digits; i++) v = {v[11:0], parse_nibs[first + i]};
      return v << (4 * (4 - digits));
   endfunction

   // Advance the parse model by one byte; returns 1 when the byte closes a spec
   function automatic bit parse_char(input logic [7:0] c, input logic last,
                                     output rsp_type color);
      int         d;
      int         digits;
      logic [3:0] span;
      color = '0;
      if (parse_pos == '0) begin
         if (c != HASH_CHAR) parse_bad = 1'b1;
      end else if (parse_pos <= POS_LAST_NIB) begin
         d = hex_value(c);
         if (d < 0) parse_bad = 1'b1;
         else parse_nibs[parse_pos - 1] = d[3:0];
      end
      // position saturates, marking the spec as too long
      span = (parse_pos == POS_SATURATE) ? POS_SATURATE : parse_pos + 4'd1;
      parse_pos = span;
      if (!last) return 1'b0;
      if (!parse_bad && (span == LEN_DIGITS_1 || span == LEN_DIGITS_2 ||
                         span == LEN_DIGITS_3 || span == LEN_DIGITS_4)) begin
         digits          = (int'(span) - 1) / 3;
         color.valid_res = 1'b1;
         color.red       = gather(0, digits);
         color.green     = gather(digits, digits);
         color.blue      = gather(2 * digits, digits);
         color.pixel     = {ALPHA_OPAQUE, color.red[15:8], color.green[15:8],
                            color.blue[15:8]};
      end
      parse_clear();
      return 1'b1;
   endfunction

   function automatic logic [7:0] any_digit();
      string set = "0123456789abcdefABCDEF";
      return set[$urandom_range(0, 21)];
   endfunction

   // Offer one byte until it transfers, then update the model
   task automatic send_char(input logic [7:0] c, input logic last,
                            input bit typed, input rsp_type want);
      rsp_type color;
      while (!quiet && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{char_code: c, is_last: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_sent++;
      if (parse_char(c, last, color)) begin
         color_q.push_back(typed ? want : color);
         specs_done++;
         good_specs += color.valid_res;
      end
   endtask

   task automatic report(input string what, input rsp_type want, input rsp_type got);
      faults++;
      if (faults <= 10)
         $display("%s: expected v=%0b r=%h g=%h b=%h px=%h, got v=%0b r=%h g=%h b=%h px=%h",
                  what, want.valid_res, want.red, want.green, want.blue, want.pixel,
                  got.valid_res, got.red, got.green, got.blue, got.pixel);
   endtask

   // Response side: random stalls, long hold-offs on request, and the result check
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            hold_left   = 80;
         end
         if (rsp_valid && !rsp_stall) begin
            if (color_q.size() == 0) begin
               report("unexpected result", '0, rsp_data);
            end else begin
               color_front = color_q.pop_front();
               checked++;
               if (color_front.valid_res !== rsp_data.valid_res ||
                   color_front.red !== rsp_data.red || color_front.green !== rsp_data.green ||
                   color_front.blue !== rsp_data.blue || color_front.pixel !== rsp_data.pixel)
                  report("mismatch", color_front, rsp_data);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 7);
         end
      end
   end

   initial begin
      logic [7:0] spec [$];
      int         kind;
      int         n;
      parse_clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: lone '#', mixed-case short form, zero and 0xFF bytes, too long
      dir_specs[0] = '{"#", 1, 1'b1, '0};
      dir_specs[1] = '{"#fA9", 4, 1'b1,
                       '{1'b1, 16'hF000, 16'hA000, 16'h9000, 32'hFFF0A090}};
      dir_specs[2] = '{{"#", 8'h00, 8'hFF, "0"}, 4, 1'b1, '0};
      dir_specs[3] = '{"#0000000000000", 14, 1'b1, '0};
      foreach (dir_specs[k])
         for (int i = 0; i < dir_specs[k].len; i++)
            send_char(dir_specs[k].text[dir_specs[k].len - 1 - i],
                      i == dir_specs[k].len - 1, dir_specs[k].typed, dir_specs[k].want);

      // Random: mostly well-formed specs, some wrong lengths, corrupted and noise
      hold_asks <= hold_asks + 1;
      while (chars_sent < 825) begin
         quiet <= (chars_sent > 350 && chars_sent < 500);
         if (specs_done == 150) hold_asks <= hold_asks + 1;
         spec.delete();
         kind = $urandom_range(0, 99);
         if (kind < 80) begin
            n = (kind < 65) ? 3 * $urandom_range(1, 4) : $urandom_range(0, 16);
            spec.push_back((kind < 65 || $urandom_range(0, 1)) ? HASH_CHAR : any_digit());
            repeat (n) spec.push_back(any_digit());
         end else if (kind < 90) begin
            spec.push_back(HASH_CHAR);
            repeat (3 * $urandom_range(1, 4)) spec.push_back(any_digit());
            spec[$urandom_range(0, spec.size() - 1)] = 8'($urandom_range(0, 255));
         end else begin
            repeat ($urandom_range(1, 16)) spec.push_back(8'($urandom_range(0, 255)));
         end
         foreach (spec[i]) send_char(spec[i], i == spec.size() - 1, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (color_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("ran %0d specs (%0d well formed) over %0d characters; %0d results checked",
               specs_done, good_specs, chars_sent, checked);
      if (faults == 0)
         $display("hex_color_spec_parser_test: clean");
      else
         $display("hex_color_spec_parser_test: errors");
      $finish;
   end

endmodule

// File: filelist.f
design/hcsp_pkg.sv
design/hcsp_step.sv
design/hex_color_spec_parser.sv
tb/hex_color_spec_parser_test.sv
